### rtl/core/tga_rle_pixel_decoder_assert.svh
// Assertion macros for the Targa RLE pixel decoder.
// All checks run on clk_i and are held off while rst_ni is low.
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

// Check that a property holds at every rising clock edge.
`define TGARLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define TGARLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/tgarle_pkg.sv
package tgarle_pkg;

  localparam int unsigned PixelW   = 32;
  localparam int unsigned NBytesW  = 3;
  localparam int unsigned CountW   = 8;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned AddrW    = 4;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_PIXEL_BYTES  = 2'd0;
  localparam logic [1:0] REG_RLE_ENABLE   = 2'd1;
  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd2;
  localparam logic [1:0] REG_ALPHA_BITS   = 2'd3;

  // Pixel format codes
  localparam logic [1:0] FMT_PASS = 2'd0;
  localparam logic [1:0] FMT_BGR  = 2'd1;
  localparam logic [1:0] FMT_555  = 2'd2;

  localparam logic [7:0] RunThreshold = 8'd128;
  localparam logic [7:0] RunBias      = 8'd127;

  typedef enum logic [1:0] {
    MODE_HEADER = 2'd0,
    MODE_REPEAT = 2'd1,
    MODE_RAW    = 2'd2
  } mode_e;

  typedef struct packed {
    logic [2:0] pixel_bytes;
    logic       rle_enable;
    logic [1:0] pixel_format;
    logic [3:0] alpha_bits;
  } cfg_t;

  // Gathered pixel leaving the packet parser
  typedef struct packed {
    logic              valid;
    logic [PixelW-1:0] sample;
    logic [CountW-1:0] count;
  } sample_t;

  // Converted result item
  typedef struct packed {
    logic [CountW-1:0]  run_count;
    logic [NBytesW-1:0] out_bytes;
    logic [PixelW-1:0]  pixel_word;
  } pix_t;

  // Bytes per pixel, with out-of-range codes clamped to 1..4
  function automatic logic [2:0] eff_bytes(input logic [2:0] pb);
    logic [2:0] n;
    if (pb == 3'd0) begin
      n = 3'd1;
    end else if (pb > 3'd4) begin
      n = 3'd4;
    end else begin
      n = pb;
    end
    return n;
  endfunction

endpackage

### rtl/core/tgarle_parser.sv
module tgarle_parser
  import tgarle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  input  logic       frame_start_i,
  output sample_t    sample_o
);

  mode_e       mode_q, mode_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] shift_q, shift_d;
  logic [7:0]  run_q, run_d;

  // State as seen after an optional frame-start clear
  mode_e       mode_c;
  logic [7:0]  left_c;
  logic [1:0]  idx_c;
  logic [31:0] shift_c;
  logic [7:0]  run_c;

  logic [1:0]  last_idx;
  logic [31:0] gathered;
  logic        complete;
  logic [2:0]  nbytes;

  always_comb begin
    nbytes   = eff_bytes(cfg_i.pixel_bytes);
    last_idx = 2'(nbytes - 3'd1);

    if (frame_start_i) begin
      mode_c  = MODE_HEADER;
      left_c  = '0;
      idx_c   = '0;
      shift_c = '0;
      run_c   = '0;
    end else begin
      mode_c  = mode_q;
      left_c  = left_q;
      idx_c   = idx_q;
      shift_c = shift_q;
      run_c   = run_q;
    end

    gathered = shift_c | (32'(byte_i) << {idx_c, 3'b000});
    complete = (idx_c >= last_idx);

    mode_d  = mode_c;
    left_d  = left_c;
    run_d   = run_c;
    idx_d   = complete ? 2'd0 : 2'(idx_c + 2'd1);
    shift_d = complete ? 32'd0 : gathered;

    sample_o.valid  = 1'b0;
    sample_o.sample = gathered;
    sample_o.count  = 8'd1;

    if (!cfg_i.rle_enable) begin
      sample_o.valid = complete;
    end else begin
      unique case (mode_c)
        MODE_REPEAT: begin
          if (complete) begin
            sample_o.valid = 1'b1;
            sample_o.count = run_c;
            run_d          = '0;
            mode_d         = MODE_HEADER;
          end
        end
        MODE_RAW: begin
          if (complete) begin
            sample_o.valid = 1'b1;
            left_d         = left_c - 8'd1;
            if (left_d == 8'd0) begin
              mode_d = MODE_HEADER;
            end
          end
        end
        default: begin
          // header byte: open a packet, drop any partial pixel
          idx_d   = '0;
          shift_d = '0;
          if (byte_i >= RunThreshold) begin
            run_d  = byte_i - RunBias;
            mode_d = MODE_REPEAT;
          end else begin
            left_d = byte_i + 8'd1;
            mode_d = MODE_RAW;
          end
        end
      endcase
    end

    sample_o.valid = sample_o.valid & take_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HEADER;
      left_q  <= '0;
      idx_q   <= '0;
      shift_q <= '0;
      run_q   <= '0;
    end else if (take_i) begin
      mode_q  <= mode_d;
      left_q  <= left_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      run_q   <= run_d;
    end
  end

endmodule

### rtl/core/tgarle_convert.sv
module tgarle_convert
  import tgarle_pkg::*;
(
  input  cfg_t    cfg_i,
  input  sample_t sample_i,
  output pix_t    pix_o
);

  logic [7:0] b0, b1, b2, b3;
  logic [7:0] r5, g5, bl5;
  logic [2:0] nbytes;

  function automatic logic [7:0] widen5(input logic [7:0] v);
    return v + (v >> 5);
  endfunction

  always_comb begin
    b0 = sample_i.sample[7:0];
    b1 = sample_i.sample[15:8];
    b2 = sample_i.sample[23:16];
    b3 = sample_i.sample[31:24];

    r5  = (b1 << 1) & 8'hf8;
    g5  = ((b0 & 8'he0) >> 2) + ((b1 & 8'h03) << 6);
    bl5 = (b0 << 3) & 8'hf8;

    nbytes = eff_bytes(cfg_i.pixel_bytes);

    pix_o.run_count = sample_i.count;

    unique case (cfg_i.pixel_format)
      FMT_BGR: begin
        pix_o.pixel_word = {8'h00, b0, b1, b2};
        pix_o.out_bytes  = 3'd3;
        if (cfg_i.alpha_bits != 4'd0) begin
          pix_o.pixel_word[31:24] = b3;
          pix_o.out_bytes         = 3'd4;
        end
      end
      FMT_555: begin
        pix_o.pixel_word = {8'h00, widen5(bl5), widen5(g5), widen5(r5)};
        pix_o.out_bytes  = 3'd3;
        if (cfg_i.alpha_bits == 4'd1) begin
          // set top bit means transparent
          pix_o.pixel_word[31:24] = b1[7] ? 8'h00 : 8'hff;
          pix_o.out_bytes         = 3'd4;
        end
      end
      default: begin
        pix_o.out_bytes  = nbytes;
        pix_o.pixel_word = {(nbytes >= 3'd4) ? b3 : 8'h00,
                            (nbytes >= 3'd3) ? b2 : 8'h00,
                            (nbytes >= 3'd2) ? b1 : 8'h00,
                            b0};
      end
    endcase
  end

endmodule

### rtl/core/tgarle_outbuf.sv
module tgarle_outbuf
  import tgarle_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t data_i,
  output logic space_o,
  output logic valid_o,
  input  logic ready_i,
  output pix_t data_o
);

  pix_t       entry_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = valid_o & ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign data_o  = entry_q[0];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      // advance the second entry, or take the new one behind the popped head
      if (push_i && cnt_q == 2'd1) begin
        entry_q[0] <= data_i;
      end else begin
        entry_q[0] <= entry_q[1];
        if (push_i) begin
          entry_q[1] <= data_i;
        end
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        entry_q[0] <= data_i;
      end else begin
        entry_q[1] <= data_i;
      end
    end
  end

endmodule

### rtl/core/tga_rle_pixel_decoder.sv
// Targa pixel-data decoder. Takes one stream byte per cycle on the slave side
// and gives at most one converted pixel per byte on the master side, each with
// the count of times a downstream stage should repeat it (runs stay packed).
// A byte is taken every cycle as long as the two-entry output buffer has room;
// the packet state and byte gathering update at the accepting edge and the
// converted result is written into that buffer, from which the master side is
// served in order. Assert tuser with the first byte
// of a frame to clear packet state. Write the APB registers only while the
// block is idle.
`include "tga_rle_pixel_decoder_assert.svh"

module tga_rle_pixel_decoder
  import tgarle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tuser,   // [0] frame_start
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] pixel_word, [34:32] out_bytes, [42:35] run_count, [47:43] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t    cfg_q;
  logic    take;
  logic    space;
  logic    cfg_wr;
  sample_t sample;
  pix_t    pix_new;
  pix_t    pix_out;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_bytes  <= 3'd3;
      cfg_q.rle_enable   <= 1'b1;
      cfg_q.pixel_format <= FMT_PASS;
      cfg_q.alpha_bits   <= 4'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PIXEL_BYTES:  cfg_q.pixel_bytes  <= pwdata[2:0];
        REG_RLE_ENABLE:   cfg_q.rle_enable   <= pwdata[0];
        REG_PIXEL_FORMAT: cfg_q.pixel_format <= pwdata[1:0];
        REG_ALPHA_BITS:   cfg_q.alpha_bits   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PIXEL_BYTES:  prdata = {29'd0, cfg_q.pixel_bytes};
      REG_RLE_ENABLE:   prdata = {31'd0, cfg_q.rle_enable};
      REG_PIXEL_FORMAT: prdata = {30'd0, cfg_q.pixel_format};
      REG_ALPHA_BITS:   prdata = {28'd0, cfg_q.alpha_bits};
      default:          prdata = '0;
    endcase
  end

  assign s_axis_tready = space;
  assign take          = s_axis_tvalid & space;

  tgarle_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .take_i       (take),
    .byte_i       (s_axis_tdata),
    .frame_start_i(s_axis_tuser),
    .sample_o     (sample)
  );

  tgarle_convert u_convert (
    .cfg_i   (cfg_q),
    .sample_i(sample),
    .pix_o   (pix_new)
  );

  tgarle_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (sample.valid),
    .data_i (pix_new),
    .space_o(space),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (pix_out)
  );

  assign m_axis_tdata = {5'd0, pix_out.run_count, pix_out.out_bytes, pix_out.pixel_word};

  `TGARLE_ASSERT_IMP(a_run_nonzero, m_axis_tvalid,
                     m_axis_tdata[42:35] != 8'd0, "zero run count")
  `TGARLE_ASSERT_IMP(a_nbytes_range, m_axis_tvalid,
                     (m_axis_tdata[34:32] != 3'd0) && (m_axis_tdata[34:32] <= 3'd4),
                     "out_bytes out of range")
  `TGARLE_ASSERT_IMP(a_full_has_out, !s_axis_tready, m_axis_tvalid,
                     "stalled input with empty output")
  `TGARLE_ASSERT(a_one_byte_clean,
                 !(m_axis_tvalid && m_axis_tdata[34:32] == 3'd1) || (m_axis_tdata[31:8] == 24'd0),
                 "bytes above out_bytes not zero")

endmodule

### dv/tga_rle_pixel_decoder_test.sv
module tga_rle_pixel_decoder_test;
  import tgarle_pkg::*;

  localparam logic [1:0] FMT_UNUSED = 2'd3;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE       = 4;
  localparam int PHASE_BYTES  = 60;
  localparam int RANDOM_PHASES = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  tga_rle_pixel_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // Decoder mirror: configuration and packet state
  cfg_t        cfg_m;
  mode_e       mode_m;
  logic [7:0]  left_m;
  logic [1:0]  idx_m;
  logic [31:0] sample_m;
  logic [7:0]  run_m;
  pix_t        pixels_due[$];

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  pixels_checked = 0;
  int  runs_checked = 0;
  int  configs_used = 0;
  bit  tx_jitter = 1'b0;
  bit  rx_jitter = 1'b0;
  bit  hold_off_req = 1'b0;

  function automatic void log_mismatch(string what, longint unsigned want,
                                       longint unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0s: expected %0h, got %0h", what, want, got);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic int pixel_size(logic [2:0] pb);
    if (pb == 3'd0) return 1;
    if (pb > 3'd4) return 4;
    return int'(pb);
  endfunction

  function automatic logic [7:0] widen5(logic [7:0] v);
    return v + {5'b0, v[7:5]};
  endfunction

  function automatic void clear_packet();
    mode_m   = MODE_HEADER;
    left_m   = '0;
    idx_m    = '0;
    sample_m = '0;
    run_m    = '0;
  endfunction

  // Add one byte to the pixel being gathered; 1 when the pixel is complete.
  function automatic bit gather_byte(logic [7:0] d);
    sample_m = sample_m | (32'(d) << (8 * idx_m));
    if (int'(idx_m) + 1 >= pixel_size(cfg_m.pixel_bytes)) begin
      idx_m = '0;
      return 1'b1;
    end
    idx_m = idx_m + 2'd1;
    return 1'b0;
  endfunction

  function automatic void emit_pixel(logic [7:0] count);
    pix_t p;
    logic [7:0] b0, b1, b2, b3;
    int n;
    {b3, b2, b1, b0} = sample_m;
    p.run_count = count;
    if (cfg_m.pixel_format == FMT_BGR) begin
      p.pixel_word = {8'h00, b0, b1, b2};
      n = 3;
      if (cfg_m.alpha_bits != 4'd0) begin
        p.pixel_word[31:24] = b3;
        n = 4;
      end
    end else if (cfg_m.pixel_format == FMT_555) begin
      p.pixel_word = {8'h00,
                      widen5({b0[4:0], 3'b000}),
                      widen5({2'b00, b0[7:5], 3'b000} + {b1[1:0], 6'b0}),
                      widen5({b1[6:2], 3'b000})};
      n = 3;
      if (cfg_m.alpha_bits == 4'd1) begin
        p.pixel_word[31:24] = b1[7] ? 8'h00 : 8'hff;
        n = 4;
      end
    end else begin
      n = pixel_size(cfg_m.pixel_bytes);
      p.pixel_word = (n >= 4) ? sample_m : sample_m & ((32'h1 << (8 * n)) - 32'h1);
    end
    p.out_bytes = 3'(n);
    sample_m = '0;
    pixels_due.push_back(p);
  endfunction

  function automatic void decode_byte(logic [7:0] d, logic fs);
    if (fs) clear_packet();
    if (!cfg_m.rle_enable) begin
      if (gather_byte(d)) emit_pixel(8'd1);
      return;
    end
    case (mode_m)
      MODE_REPEAT: begin
        if (gather_byte(d)) begin
          emit_pixel(run_m);
          run_m  = '0;
          mode_m = MODE_HEADER;
        end
      end
      MODE_RAW: begin
        if (gather_byte(d)) begin
          emit_pixel(8'd1);
          left_m = left_m - 8'd1;
          if (left_m == 8'd0) mode_m = MODE_HEADER;
        end
      end
      default: begin
        idx_m    = '0;
        sample_m = '0;
        if (d >= RunThreshold) begin
          run_m  = d - RunBias;
          mode_m = MODE_REPEAT;
        end else begin
          left_m = d + 8'd1;
          mode_m = MODE_RAW;
        end
      end
    endcase
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    pix_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixels_due.size() == 0) begin
        log_mismatch("unexpected pixel", 0, m_axis_tdata);
      end else begin
        want = pixels_due.pop_front();
        pixels_checked++;
        if (want.run_count > 8'd1) runs_checked++;
        if (m_axis_tdata[31:0] !== want.pixel_word)
          log_mismatch("pixel_word", want.pixel_word, m_axis_tdata[31:0]);
        if (m_axis_tdata[34:32] !== want.out_bytes)
          log_mismatch("out_bytes", want.out_bytes, m_axis_tdata[34:32]);
        if (m_axis_tdata[42:35] !== want.run_count)
          log_mismatch("run_count", want.run_count, m_axis_tdata[42:35]);
        if (m_axis_tdata[47:43] !== 5'b0)
          log_mismatch("tdata padding", 0, m_axis_tdata[47:43]);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = LONG_HOLD;
      end else if (stall == 0 && rx_jitter) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= rst_ni;
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic fs);
    int gap;
    gap = tx_jitter ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(d, fs);
    bytes_sent++;
  endtask

  task automatic send_random_bytes(input int count);
    repeat (count) send_byte(8'($urandom()), 1'b0);
  endtask

  // Stop offering, wait for every expected pixel, then let the block settle
  task automatic drain_results();
    int waited;
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pixels_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE) @(posedge clk_i);
    while (pixels_due.size() != 0) begin
      log_mismatch("missing pixel", pixels_due[0], 0);
      void'(pixels_due.pop_front());
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PIXEL_BYTES:  cfg_m.pixel_bytes  = value[2:0];
      REG_RLE_ENABLE:   cfg_m.rle_enable   = value[0];
      REG_PIXEL_FORMAT: cfg_m.pixel_format = value[1:0];
      REG_ALPHA_BITS:   cfg_m.alpha_bits   = value[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [2:0] pb, input logic rle,
                            input logic [1:0] fmt, input logic [3:0] ab);
    drain_results();
    write_reg(REG_PIXEL_BYTES, 32'(pb));
    write_reg(REG_RLE_ENABLE, 32'(rle));
    write_reg(REG_PIXEL_FORMAT, 32'(fmt));
    write_reg(REG_ALPHA_BITS, 32'(ab));
    configs_used++;
  endtask

  // One packet with random content; now and then truncated, restarted or junk
  task automatic send_packet();
    int kind, size, len;
    logic fs;
    logic [7:0] header;
    kind = $urandom_range(99);
    size = pixel_size(cfg_m.pixel_bytes);
    fs   = ($urandom_range(19) == 0);
    if (kind < 45) begin
      header = 8'($urandom_range(255, 128));
      len = size;
    end else if (kind < 92) begin
      if (size <= 2 && $urandom_range(15) == 0) header = 8'($urandom_range(127, 64));
      else header = 8'($urandom_range(7));
      len = (int'(header) + 1) * size;
    end else begin
      repeat ($urandom_range(6, 1)) send_byte(8'($urandom()), 1'($urandom_range(3) == 0));
      return;
    end
    if ($urandom_range(19) == 0) len = $urandom_range(len - 1);
    send_byte(header, fs);
    send_random_bytes(len);
  endtask

  task automatic test_reset_config();
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'h80, 1'b0);
    send_random_bytes(3);
    send_byte(8'h00, 1'b0);
    send_random_bytes(3);
    send_byte(8'h7f, 1'b0);
    send_random_bytes(4);
  endtask

  // Restart in the middle of a raw packet and of a repeat sample
  task automatic test_frame_restart();
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    send_byte(8'h01, 1'b1);
    send_random_bytes(2);
    send_byte(8'h82, 1'b1);
    send_random_bytes(2);
    send_byte(8'h00, 1'b1);
    send_random_bytes(3);
  endtask

  task automatic test_formats();
    set_config(3'd2, 1'b1, FMT_555, 4'd1);
    send_byte(8'h81, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h1f, 1'b0);
    send_byte(8'h7c, 1'b0);
    // 555 from a one-byte pixel: the high byte reads as zero
    set_config(3'd1, 1'b0, FMT_555, 4'd0);
    send_byte(8'he7, 1'b1);
    send_byte(8'h1f, 1'b0);
    set_config(3'd4, 1'b0, FMT_BGR, 4'd15);
    send_random_bytes(4);
    set_config(3'd2, 1'b0, FMT_BGR, 4'd8);
    send_random_bytes(2);
    set_config(3'd7, 1'b1, FMT_UNUSED, 4'd0);
    send_byte(8'h80, 1'b1);
    send_random_bytes(4);
    set_config(3'd0, 1'b1, FMT_PASS, 4'd0);
    send_byte(8'h01, 1'b1);
    send_random_bytes(2);
  endtask

  // Fill the output buffer behind a long stall, then idle until empty
  task automatic test_backpressure();
    set_config(3'd1, 1'b0, FMT_PASS, 4'd0);
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    hold_off_req = 1'b1;
    send_random_bytes(40);
    drain_results();
    set_config(3'd1, 1'b1, FMT_BGR, 4'd0);
    hold_off_req = 1'b1;
    repeat (20) begin
      send_byte(8'($urandom_range(255, 128)), 1'b0);
      send_random_bytes(1);
    end
    drain_results();
  endtask

  task automatic test_random();
    int start;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        set_config(3'd1, 1'b1, FMT_PASS, 4'd0);
      end else if (ph == 1) begin
        set_config(3'd4, 1'b1, FMT_BGR, 4'd15);
      end else begin
        set_config(($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1)),
                   1'($urandom_range(3) != 0), 2'($urandom_range(3)),
                   ($urandom_range(1) == 0) ? 4'($urandom_range(1)) : 4'($urandom_range(15)));
      end
      tx_jitter = ($urandom_range(3) != 0);
      rx_jitter = ($urandom_range(3) != 0);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        if (cfg_m.rle_enable) send_packet();
        else send_byte(8'($urandom()), 1'($urandom_range(49) == 0));
      end
    end
  endtask

  initial begin
    cfg_m.pixel_bytes  = 3'd3;
    cfg_m.rle_enable   = 1'b1;
    cfg_m.pixel_format = FMT_PASS;
    cfg_m.alpha_bits   = 4'd0;
    clear_packet();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_frame_restart();
    test_formats();
    test_backpressure();
    test_random();
    drain_results();

    $display("streamed %0d bytes through %0d register settings", bytes_sent, configs_used);
    $display("checked %0d pixels, %0d of them repeat runs", pixels_checked, runs_checked);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### tga_rle_pixel_decoder.f
+incdir+rtl/core
rtl/core/tgarle_pkg.sv
rtl/core/tgarle_parser.sv
rtl/core/tgarle_convert.sv
rtl/core/tgarle_outbuf.sv
rtl/core/tga_rle_pixel_decoder.sv
dv/tga_rle_pixel_decoder_test.sv
